/* rtl/fgt_pkg.sv */
// Shared types and constants for the fp32 GEMM tile.
`timescale 1ns / 1ps
package fgt_pkg;

  localparam int GROUP_COLS = 4;

  localparam logic CMD_ACC = 1'b0;
  localparam logic CMD_FIN = 1'b1;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  localparam logic [31:0] ALPHA_RESET = 32'h3F80_0000;
  localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [30:0] INF_MAG     = 31'h7F80_0000;

  typedef enum logic [2:0] {
    F_IDLE,
    F_NORM,
    F_ALIGN,
    F_SUM,
    F_RNORM,
    F_ROUND
  } fma_state_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_ACC,
    T_SCALE,
    T_BETA,
    T_OUT
  } tile_state_t;

  typedef enum logic [1:0] {
    PH_ACC,
    PH_SCALE,
    PH_BETA
  } phase_t;

  typedef struct packed {
    logic       start;
    phase_t     phase;
    logic [1:0] row;
    logic [1:0] grp;
  } lane_ctl_t;

endpackage

/* rtl/fp32_gemm_tile_4x16.sv */
// Top level of the fp32 GEMM tile: sequencer, lane array and row merge.
//
// Usage: requests enter on in_valid/in_ready. An accumulate request updates
// the 16 accumulators of one column group with fused multiply-adds in 16
// parallel lanes and gives no result. A finish request scales the four
// accumulators of one row and column group by alpha, adds beta * old C when
// beta is nonzero, clears those entries and delivers one result on
// out_valid/out_ready. cfg_we writes alpha (index 0) or beta (index 1).
// One request is worked at a time. The length of a lane pass is set by the
// iterative normalize steps of the multiply-add unit (8 or 1 bit per cycle
// before alignment and after the add). Accumulate requests take one pass,
// finish requests one pass, or two when beta is nonzero, and then a load of
// the output register. A new request is taken while a result waits in the
// output register; a finish stalls only if the previous result has still
// not been taken. Reset clears all accumulators to +0, sets alpha to 1.0
// and beta to 0 and empties the output register.
`timescale 1ns / 1ps
module fp32_gemm_tile_4x16 #(
  parameter int TILE_ROWS = 4,
  parameter int TILE_COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [1:0]  in_row_sel,
  input  logic [1:0]  in_col_group,
  input  logic [31:0] in_a_row0,
  input  logic [31:0] in_a_row1,
  input  logic [31:0] in_a_row2,
  input  logic [31:0] in_a_row3,
  input  logic [31:0] in_data0,
  input  logic [31:0] in_data1,
  input  logic [31:0] in_data2,
  input  logic [31:0] in_data3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row,
  output logic [1:0]  out_group,
  output logic [31:0] out_c_out0,
  output logic [31:0] out_c_out1,
  output logic [31:0] out_c_out2,
  output logic [31:0] out_c_out3,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import fgt_pkg::*;

  tile_state_t state_r, state_nxt;
  logic        start_r, start_nxt;
  logic        accept, out_load, lanes_idle, beta_nz;
  logic [31:0] alpha_r, beta_r;
  logic        cmd_r;
  logic [1:0]  row_r, grp_r;
  logic [31:0] a_r [4];
  logic [31:0] d_r [4];
  logic [15:0] lane_busy;
  logic [31:0] lane_res [4][4];
  lane_ctl_t   ctl;
  phase_t      phase;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_row_r, out_group_r;
  logic [31:0] c_out_r [4];

  assign accept     = in_valid & in_ready;
  assign lanes_idle = (lane_busy == 16'd0) & ~start_r;
  assign beta_nz    = beta_r[30:0] != 31'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:  if (accept) state_nxt = (in_command == CMD_FIN) ? T_SCALE : T_ACC;
      T_ACC:   if (lanes_idle) state_nxt = T_IDLE;
      T_SCALE: if (lanes_idle) state_nxt = beta_nz ? T_BETA : T_OUT;
      T_BETA:  if (lanes_idle) state_nxt = T_OUT;
      T_OUT:   if (!out_valid_r || out_ready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    start_nxt = 1'b0;
    phase     = PH_ACC;
    case (state_r)
      T_IDLE: begin
        in_ready  = 1'b1;
        start_nxt = in_valid;
      end
      T_ACC:   phase = PH_ACC;
      T_SCALE: begin
        phase     = PH_SCALE;
        start_nxt = lanes_idle & beta_nz;
      end
      T_BETA:  phase = PH_BETA;
      T_OUT:   out_load = !out_valid_r || out_ready;
      default: phase = PH_ACC;
    endcase
  end

  assign ctl = '{start: start_r, phase: phase, row: row_r, grp: grp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      start_r <= 1'b0;
      alpha_r <= ALPHA_RESET;
      beta_r  <= 32'd0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      if (cfg_we && cfg_index == CFG_ALPHA) alpha_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_BETA) beta_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      row_r  <= in_row_sel;
      grp_r  <= in_col_group;
      a_r[0] <= in_a_row0;
      a_r[1] <= in_a_row1;
      a_r[2] <= in_a_row2;
      a_r[3] <= in_a_row3;
      d_r[0] <= in_data0;
      d_r[1] <= in_data1;
      d_r[2] <= in_data2;
      d_r[3] <= in_data3;
    end
  end

  for (genvar gr = 0; gr < 4; gr++) begin : g_row
    for (genvar gj = 0; gj < 4; gj++) begin : g_col
      fgt_lane #(
        .ROW       (gr),
        .COL       (gj),
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .a_val (a_r[gr]),
        .d_val (d_r[gj]),
        .alpha (alpha_r),
        .beta  (beta_r),
        .busy  (lane_busy[gr*4+gj]),
        .res   (lane_res[gr][gj])
      );
    end
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load && cmd_r == CMD_FIN) begin
      out_row_r   <= row_r;
      out_group_r <= grp_r;
      for (int j = 0; j < 4; j++) c_out_r[j] <= lane_res[row_r][j];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_group  = out_group_r;
  assign out_c_out0 = c_out_r[0];
  assign out_c_out1 = c_out_r[1];
  assign out_c_out2 = c_out_r[2];
  assign out_c_out3 = c_out_r[3];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (lane_busy == 16'd0))
    else $error("lanes started while still busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == T_OUT))
    else $error("result appeared outside the output step");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_OUT && !out_valid_r) |=> out_valid_r)
    else $error("free output register not loaded");

endmodule

/* rtl/fgt_fma.sv */
// Multi-cycle IEEE single fused multiply-add, a * b + c with one rounding.
`timescale 1ns / 1ps
module fgt_fma (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] op_c,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic        busy,
  output logic        done,
  output logic [31:0] res
);
  import fgt_pkg::*;

  fma_state_t state_r, state_nxt;

  logic [61:0]        mp_r, mp_nxt, mc_r, mc_nxt;
  logic signed [11:0] ep_r, ep_nxt, ec_r, ec_nxt;
  logic               sp_r, sp_nxt, sc_r, sc_nxt, cz_r, cz_nxt, sub_r, sub_nxt;
  logic [62:0]        r_r, r_nxt;
  logic [31:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  logic        nan_a, nan_b, nan_c, snan_a, snan_b, snan_c;
  logic        inf_a, inf_b, inf_c, zero_a, zero_b, zero_c, inv, sp_in;
  logic        special;
  logic [31:0] spec_val;
  logic [23:0] sig_a, sig_b, sig_c;
  logic signed [11:0] ea, eb_in, ec_in;
  logic [47:0] mp48;

  logic               pbig, sbig, lost, sub_al;
  logic [61:0]        mb, ms0, shifted, ms_al;
  logic signed [11:0] e_big, e_small, dd;
  logic [5:0]         sh_al;

  logic [62:0] s63;
  logic        norm_done;

  logic [63:0]        r64, kept64, mask;
  logic signed [11:0] be, shx;
  logic [5:0]         sh;
  logic [10:0]        base_e;
  logic               uf, halfb, lownz, up;
  logic [34:0]        v;
  logic [31:0]        rnd_val;

  assign nan_a  = op_a[30:0] > INF_MAG;
  assign nan_b  = op_b[30:0] > INF_MAG;
  assign nan_c  = op_c[30:0] > INF_MAG;
  assign snan_a = nan_a & ~op_a[22];
  assign snan_b = nan_b & ~op_b[22];
  assign snan_c = nan_c & ~op_c[22];
  assign inf_a  = op_a[30:0] == INF_MAG;
  assign inf_b  = op_b[30:0] == INF_MAG;
  assign inf_c  = op_c[30:0] == INF_MAG;
  assign zero_a = op_a[30:0] == 31'd0;
  assign zero_b = op_b[30:0] == 31'd0;
  assign zero_c = op_c[30:0] == 31'd0;
  assign inv    = (inf_a & zero_b) | (zero_a & inf_b);
  assign sp_in  = op_a[31] ^ op_b[31];

  assign sig_a = {|op_a[30:23], op_a[22:0]};
  assign sig_b = {|op_b[30:23], op_b[22:0]};
  assign sig_c = {|op_c[30:23], op_c[22:0]};
  assign ea    = (op_a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, op_a[30:23]}) - 12'sd150;
  assign eb_in = (op_b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, op_b[30:23]}) - 12'sd150;
  assign ec_in = (op_c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, op_c[30:23]}) - 12'sd150;
  assign mp48  = sig_a * sig_b;

  always_comb begin
    special  = 1'b1;
    spec_val = DEFAULT_NAN;
    if (nan_a | nan_b | nan_c) begin
      if (nan_c & ~snan_c & inv) spec_val = DEFAULT_NAN;
      else if (snan_c) spec_val = op_c | QUIET_BIT;
      else if (snan_a) spec_val = op_a | QUIET_BIT;
      else if (snan_b) spec_val = op_b | QUIET_BIT;
      else if (nan_c) spec_val = op_c | QUIET_BIT;
      else if (nan_a) spec_val = op_a | QUIET_BIT;
      else spec_val = op_b | QUIET_BIT;
    end else if (inv) begin
      spec_val = DEFAULT_NAN;
    end else if (inf_c) begin
      if ((inf_a | inf_b) & (sp_in != op_c[31])) spec_val = DEFAULT_NAN;
      else spec_val = op_c;
    end else if (inf_a | inf_b) begin
      spec_val = {sp_in, INF_MAG};
    end else if (zero_a | zero_b) begin
      if (zero_c) spec_val = {sp_in & op_c[31], 31'd0};
      else spec_val = op_c;
    end else begin
      special = 1'b0;
    end
  end

  always_comb begin
    pbig    = (ep_r > ec_r) || ((ep_r == ec_r) && (mp_r >= mc_r));
    mb      = pbig ? mp_r : mc_r;
    ms0     = pbig ? mc_r : mp_r;
    e_big   = pbig ? ep_r : ec_r;
    e_small = pbig ? ec_r : ep_r;
    sbig    = pbig ? sp_r : sc_r;
    dd      = e_big - e_small;
    sh_al   = dd[5:0];
    shifted = ms0 >> sh_al;
    lost    = (shifted << sh_al) != ms0;
    ms_al   = (dd >= 12'sd63) ? 62'd1 : (shifted | {61'd0, lost});
    sub_al  = sp_r ^ sc_r;
    if (cz_r) begin
      mb     = mp_r;
      e_big  = ep_r;
      sbig   = sp_r;
      ms_al  = 62'd0;
      sub_al = 1'b0;
    end
  end

  assign s63 = sub_r ? ({1'b0, mp_r} - {1'b0, mc_r}) : ({1'b0, mp_r} + {1'b0, mc_r});
  assign norm_done = mp_r[61] & (cz_r | mc_r[61]);

  always_comb begin
    r64    = {1'b0, r_r};
    be     = ep_r + 12'sd189;
    shx    = 12'sd40 - be;
    uf     = (be < 12'sd1) && (shx > 12'sd63);
    sh     = (be >= 12'sd1) ? 6'd39 : shx[5:0];
    base_e = (be >= 12'sd1) ? be[10:0] - 11'd1 : 11'd0;
    kept64 = r64 >> sh;
    halfb  = r64[sh - 6'd1];
    mask   = (64'd1 << (sh - 6'd1)) - 64'd1;
    lownz  = |(r64 & mask);
    up     = halfb & (lownz | kept64[0]);
    v      = {1'b0, base_e, 23'd0} + {10'd0, kept64[24:0]} + {34'd0, up};
    if (uf) rnd_val = {sp_r, 31'd0};
    else if (v >= 35'h0_7F80_0000) rnd_val = {sp_r, INF_MAG};
    else rnd_val = {sp_r, v[30:0]};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (start && !special) state_nxt = F_NORM;
      F_NORM:  if (norm_done) state_nxt = F_ALIGN;
      F_ALIGN: state_nxt = F_SUM;
      F_SUM:   state_nxt = (s63 == 63'd0) ? F_IDLE : F_RNORM;
      F_RNORM: if (r_r[62]) state_nxt = F_ROUND;
      F_ROUND: state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    mp_nxt   = mp_r;
    mc_nxt   = mc_r;
    ep_nxt   = ep_r;
    ec_nxt   = ec_r;
    sp_nxt   = sp_r;
    sc_nxt   = sc_r;
    cz_nxt   = cz_r;
    sub_nxt  = sub_r;
    r_nxt    = r_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          if (special) begin
            res_nxt  = spec_val;
            done_nxt = 1'b1;
          end else begin
            mp_nxt = {14'd0, mp48};
            mc_nxt = {38'd0, sig_c};
            ep_nxt = ea + eb_in;
            ec_nxt = ec_in;
            sp_nxt = sp_in;
            sc_nxt = op_c[31];
            cz_nxt = zero_c;
          end
        end
      end
      F_NORM: begin
        if (mp_r[61:54] == 8'd0) begin
          mp_nxt = mp_r << 8;
          ep_nxt = ep_r - 12'sd8;
        end else if (!mp_r[61]) begin
          mp_nxt = mp_r << 1;
          ep_nxt = ep_r - 12'sd1;
        end
        if (!cz_r) begin
          if (mc_r[61:54] == 8'd0) begin
            mc_nxt = mc_r << 8;
            ec_nxt = ec_r - 12'sd8;
          end else if (!mc_r[61]) begin
            mc_nxt = mc_r << 1;
            ec_nxt = ec_r - 12'sd1;
          end
        end
      end
      F_ALIGN: begin
        mp_nxt  = mb;
        mc_nxt  = ms_al;
        ep_nxt  = e_big;
        sp_nxt  = sbig;
        sub_nxt = sub_al;
      end
      F_SUM: begin
        r_nxt = s63;
        if (s63 == 63'd0) begin
          res_nxt  = 32'd0;
          done_nxt = 1'b1;
        end
      end
      F_RNORM: begin
        if (r_r[62:55] == 8'd0) begin
          r_nxt  = r_r << 8;
          ep_nxt = ep_r - 12'sd8;
        end else if (!r_r[62]) begin
          r_nxt  = r_r << 1;
          ep_nxt = ep_r - 12'sd1;
        end
      end
      F_ROUND: begin
        res_nxt  = rnd_val;
        done_nxt = 1'b1;
      end
      default: done_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    mp_r  <= mp_nxt;
    mc_r  <= mc_nxt;
    ep_r  <= ep_nxt;
    ec_r  <= ec_nxt;
    sp_r  <= sp_nxt;
    sc_r  <= sc_nxt;
    cz_r  <= cz_nxt;
    sub_r <= sub_nxt;
    r_r   <= r_nxt;
    res_r <= res_nxt;
  end

  assign busy = state_r != F_IDLE;
  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/fgt_lane.sv */
// One accumulator lane: four column-group entries and a fused multiply-add unit.
`timescale 1ns / 1ps
module fgt_lane #(
  parameter int ROW       = 0,
  parameter int COL       = 0,
  parameter int TILE_ROWS = 4,
  parameter int TILE_COLS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fgt_pkg::lane_ctl_t ctl,
  input  logic [31:0]       a_val,
  input  logic [31:0]       d_val,
  input  logic [31:0]       alpha,
  input  logic [31:0]       beta,
  output logic              busy,
  output logic [31:0]       res
);
  import fgt_pkg::*;

  logic [31:0] acc_r [4];
  logic [31:0] t_r;
  logic [31:0] op_c, op_a, op_b, fma_res;
  logic        in_tile, sel, fma_done;

  assign in_tile = (ROW < TILE_ROWS) && ((int'(ctl.grp) * GROUP_COLS + COL) < TILE_COLS);
  assign sel     = ctl.row == 2'(ROW);

  always_comb begin
    case (ctl.phase)
      PH_ACC: begin
        op_c = acc_r[ctl.grp];
        op_a = d_val;
        op_b = a_val;
      end
      PH_SCALE: begin
        op_c = NEG_ZERO;
        op_a = in_tile ? acc_r[ctl.grp] : 32'd0;
        op_b = alpha;
      end
      PH_BETA: begin
        op_c = t_r;
        op_a = d_val;
        op_b = beta;
      end
      default: begin
        op_c = acc_r[ctl.grp];
        op_a = d_val;
        op_b = a_val;
      end
    endcase
  end

  fgt_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.start),
    .op_c  (op_c),
    .op_a  (op_a),
    .op_b  (op_b),
    .busy  (busy),
    .done  (fma_done),
    .res   (fma_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < 4; g++) acc_r[g] <= 32'd0;
    end else if (fma_done && in_tile) begin
      if (ctl.phase == PH_ACC) acc_r[ctl.grp] <= fma_res;
      else if (ctl.phase == PH_SCALE && sel) acc_r[ctl.grp] <= 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (fma_done && ctl.phase != PH_ACC) t_r <= fma_res;
  end

  assign res = t_r;

endmodule
